// ===== hdl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet function of the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int BYTE_W = 8;
  localparam int CHAR_W = 7;
  localparam int SYM_W  = 6;
  localparam int RES_W  = 4;
  localparam int IDX_W  = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

  // position of the next byte within its three-byte group
  typedef enum logic [2:0] {
    PH0 = 3'b001,
    PH1 = 3'b010,
    PH2 = 3'b100
  } phase_t;

  // one byte's worth of characters: one or two symbols, then up to two pads
  typedef struct packed {
    logic [SYM_W-1:0] sym0;
    logic [SYM_W-1:0] sym1;
    logic             two_sym;
    logic [1:0]       npad;
    logic             last;
  } job_t;

  function automatic logic [CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] v);
    logic [CHAR_W-1:0] c;
    c = {1'b0, v};
    if (v < 6'd26) begin
      sym_to_char = 7'd65 + c;
    end else if (v < 6'd52) begin
      sym_to_char = 7'd71 + c;
    end else if (v < 6'd62) begin
      sym_to_char = c - 7'd4;
    end else if (v == 6'd62) begin
      sym_to_char = 7'd43;
    end else begin
      sym_to_char = 7'd47;
    end
  endfunction

endpackage

// ===== hdl/base64_stream_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit
// Standard-alphabet base64 encoder for a byte stream with '=' padding.
// ----------------------------------------------------------------------------
// A byte is taken in any cycle in which the two-entry job queue has room, and
// characters leave one per cycle from a registered output while the receiver
// is ready. Each byte gives one character in the first two positions of a
// group and two in the third, and a byte flagged tlast in the first or second
// position adds the flush character and pads for four or three in all; the
// output character lane, at one character per cycle, sets the sustained rate.
// tlast on the output marks the last character of each message.
module base64_stream_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] code_char, [7] zero
  output logic       m_axis_tlast
);
  import b64e_pkg::*;

  logic              fr_valid;
  logic              fr_ready;
  job_t              fr_job;
  logic              bk_valid;
  logic              bk_ready;
  job_t              bk_job;
  logic [CHAR_W-1:0] out_char;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .job_valid (fr_valid),
    .job       (fr_job),
    .job_ready (fr_ready)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_job),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_data  (bk_job)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job       (bk_job),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (out_char),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

// ===== hdl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// Takes input bytes, tracks the group position and leftover bits, and turns
// each byte into a job of symbols and pad count for the back end.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [b64e_pkg::BYTE_W-1:0] in_byte,
  input  logic                      in_last,
  output logic                      in_ready,
  output logic                      job_valid,
  output b64e_pkg::job_t            job,
  input  logic                      job_ready
);
  import b64e_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  logic [RES_W-1:0]   residual;
  logic [RES_W-1:0]   residual_next;
  logic               accept;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid && job_ready;

  always_comb begin
    job           = '0;
    job.last      = in_last;
    residual_next = '0;
    phase_next    = PH0;
    unique case (phase)
      PH1: begin
        job.sym0      = {residual[1:0], in_byte[7:4]};
        residual_next = in_byte[3:0];
        phase_next    = PH2;
      end
      PH2: begin
        job.sym0      = {residual, in_byte[7:6]};
        job.sym1      = in_byte[5:0];
        job.two_sym   = 1'b1;
        residual_next = '0;
        phase_next    = PH0;
      end
      default: begin
        job.sym0      = in_byte[7:2];
        residual_next = {2'b00, in_byte[1:0]};
        phase_next    = PH1;
      end
    endcase
    if (in_last) begin
      // flush leftover bits and pad to four characters
      if (phase_next == PH1) begin
        job.sym1    = {residual_next[1:0], 4'b0000};
        job.two_sym = 1'b1;
        job.npad    = 2'd2;
      end else if (phase_next == PH2) begin
        job.sym1    = {residual_next, 2'b00};
        job.two_sym = 1'b1;
        job.npad    = 2'd1;
      end
      residual_next = '0;
      phase_next    = PH0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH0;
      residual <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      residual <= residual_next;
    end
  end

endmodule

// ===== hdl/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module b64e_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  b64e_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output b64e_pkg::job_t rd_data
);
  import b64e_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// Walks each job one character per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  b64e_pkg::job_t              job,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [b64e_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last
);
  import b64e_pkg::*;

  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  last_idx;
  logic              at_end;
  logic              load;
  logic [CHAR_W-1:0] char_next;

  assign last_idx  = {1'b0, job.two_sym} + job.npad;
  assign at_end    = (idx == last_idx);
  assign load      = job_valid && (!out_valid || out_ready);
  assign job_ready = load && at_end;

  always_comb begin
    if (idx == 2'd0) begin
      char_next = sym_to_char(job.sym0);
    end else if (idx == 2'd1 && job.two_sym) begin
      char_next = sym_to_char(job.sym1);
    end else begin
      char_next = PAD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= char_next;
      out_last <= job.last && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== verif/base64_stream_encoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit_tb
// Streams byte messages into the encoder under several idle and stall
// patterns, computes the expected base64 characters and end marks
// alongside, and checks every character that leaves the block in order.
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit_tb;
  import b64e_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [CHAR_W-1:0] code_char;
    logic              final_char;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;   // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [6:0] code_char, [7] zero
  logic       m_axis_tlast;

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  enc_char_t          char_q[$];
  logic [RES_W-1:0]   res_bits = '0;
  phase_t             grp_phase = PH0;
  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  int                 rx_hold = 0;
  int                 mismatches = 0;
  int                 cycles = 0;

  base64_stream_encoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver side: long hold-off when requested, otherwise random stalls
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    enc_char_t exp_c;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (char_q.size() == 0) begin
        $error("unexpected word: code_char %0d final_char %0b",
               m_axis_tdata[6:0], m_axis_tlast);
        mismatches++;
      end else begin
        exp_c = char_q.pop_front();
        if (m_axis_tdata[6:0] !== exp_c.code_char) begin
          $error("code_char: expected %0d, got %0d", exp_c.code_char, m_axis_tdata[6:0]);
          mismatches++;
        end
        if (m_axis_tlast !== exp_c.final_char) begin
          $error("final_char: expected %0b, got %0b", exp_c.final_char, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  function automatic void push_sym(input logic [SYM_W-1:0] v);
    byte c;
    c = alphabet[v];
    char_q.insert(char_q.size(), enc_char_t'{code_char: c[CHAR_W-1:0], final_char: 1'b0});
  endfunction

  function automatic void push_pad();
    char_q.insert(char_q.size(), enc_char_t'{code_char: PAD_CHAR, final_char: 1'b0});
  endfunction

  // expected characters for one accepted byte
  function automatic void encode_byte(input logic [7:0] b, input logic eom);
    enc_char_t tail;
    case (grp_phase)
      PH1: begin
        push_sym({res_bits[1:0], b[7:4]});
        res_bits = b[3:0];
        grp_phase = PH2;
      end
      PH2: begin
        push_sym({res_bits, b[7:6]});
        push_sym(b[5:0]);
        res_bits = '0;
        grp_phase = PH0;
      end
      default: begin
        push_sym(b[7:2]);
        res_bits = {2'b00, b[1:0]};
        grp_phase = PH1;
      end
    endcase
    if (eom) begin
      if (grp_phase == PH1) begin
        push_sym({res_bits[1:0], 4'b0000});
        push_pad();
        push_pad();
      end else if (grp_phase == PH2) begin
        push_sym({res_bits, 2'b00});
        push_pad();
      end
      tail = char_q.pop_back();
      tail.final_char = 1'b1;
      char_q.insert(char_q.size(), tail);
      res_bits = '0;
      grp_phase = PH0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic eom);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= eom;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    encode_byte(d, eom);
  endtask

  // sender pauses until every expected word is out
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_messages(input int n_bytes);
    int left;
    left = 0;
    for (int i = 0; i < n_bytes; i++) begin
      if (left == 0) left = $urandom_range(7, 1);
      left--;
      send_byte(8'($urandom_range(255)), (left == 0) || (i == n_bytes - 1));
      if (i == n_bytes - 1) left = 0;
    end
  endtask

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_byte(8'h00, 1'b1);                            // two bits left: "AA=="
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);                            // four bits left
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);                            // group complete, '+' and '/'
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hD3, 1'b1);                            // wraps then ends in first slot
    send_byte(8'hD7, 1'b0);                            // digit symbols
    send_byte(8'h6D, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b1);
    wait_drained();
  endtask

  task automatic test_no_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_messages(18);
    wait_drained();
  endtask

  task automatic test_sender_idle();
    tx_idle_pct = 48;
    rx_idle_pct = 0;
    send_messages(18);
    wait_drained();
  endtask

  task automatic test_receiver_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 48;
    send_messages(18);
    wait_drained();
  endtask

  task automatic test_both_idle();
    tx_idle_pct = 12;
    rx_idle_pct = 12;
    send_messages(18);
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(negedge clk);
    rx_hold <= 80;
    send_messages(16);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
